### sv/assert_macros.svh
// Assertion macros used by the top level of the calendar converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

### sv/e2c_pkg.sv
// Package for the calendar converter: widths, constants, result types and divider helpers.
package e2c_pkg;

	localparam int SEC_W   = 32;
	localparam int OFF_W   = 12;
	localparam int T_W     = 33;
	localparam int DAYS_W  = 17;
	localparam int SOD_W   = 17;
	localparam int DOE_W   = 18;
	localparam int YOE_W   = 9;
	localparam int DOY_W   = 9;
	localparam int MP_W    = 4;
	localparam int YEAR_W  = 7;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WD_W    = 3;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int MTOT_W  = 11;
	localparam int YFULL_W = 12;

	// Cycles from an accepted start to the done strobe.
	localparam int PIPE_DEPTH = 10;

	// 86400 = 675 << 7: the low seven bits pass straight into the seconds of the day.
	localparam int DAY_SHIFT     = 7;
	localparam int DAY_ODD       = 675;
	localparam int DAY_X_W       = T_W - DAY_SHIFT;
	localparam int DAY_RECIP_W   = 27;
	localparam int DAY_RECIP     = 101806632;
	localparam int DAY_RECIP_SH  = 36;
	localparam int DAY_PROD_W    = DAY_X_W + DAY_RECIP_W;
	localparam int DAY_REM_W     = DAY_X_W + 1;

	localparam int DAYS_PER_ERA     = 146097;
	localparam int DAYS_TO_ERA_BASE = 719468;
	localparam int YEARS_PER_ERA    = 400;
	// Every local time in range falls into era four or era five.
	localparam int ERA_LOW    = 4;
	localparam int ERA_SPLIT  = (ERA_LOW + 1) * DAYS_PER_ERA - DAYS_TO_ERA_BASE;
	localparam int DOE_BIAS   = DAYS_TO_ERA_BASE - ERA_LOW * DAYS_PER_ERA;
	localparam int YEAR_ERA_LOW  = ERA_LOW * YEARS_PER_ERA;
	localparam int YEAR_ERA_HIGH = (ERA_LOW + 1) * YEARS_PER_ERA;

	localparam int DAYS_PER_CENT_ERA = 36524;
	localparam int LAST_DOE          = 146096;
	localparam int DAYS_PER_YEAR     = 365;

	localparam int YEAR_LOW  = 2000;
	localparam int YEAR_HIGH = 2099;

	localparam int MP_MARCH_LAST = 10;
	localparam int MONTH_FEB     = 2;
	localparam int WEEKDAY_EPOCH = 4;

	localparam int RECIP_60_WIDE = 139811;
	localparam int RECIP_60_NARR = 2185;
	localparam int RECIP_7       = 149797;
	localparam int RECIP_365     = 91930;
	localparam int RECIP_153     = 3427;

	typedef struct packed {
		logic [YEAR_W-1:0]  year_of_century;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} civil_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [MIN_W-1:0]  second;
		logic [WD_W-1:0]   weekday;
	} tod_t;

	// Seconds of the day divided by 60, exact below 86400.
	function automatic logic [MTOT_W-1:0] div60_wide(input logic [SOD_W-1:0] x);
		logic [34:0] p;
		p = 35'(x) * 35'(RECIP_60_WIDE);
		return p[33:23];
	endfunction

	// Minutes of the day divided by 60, exact below 1440.
	function automatic logic [HOUR_W-1:0] div60_narrow(input logic [MTOT_W-1:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(RECIP_60_NARR);
		return p[21:17];
	endfunction

	// Division by 7, exact below 2^20 / 3; the 14-bit result limits it to counts below 114688.
	function automatic logic [13:0] div7(input logic [DAYS_W-1:0] x);
		logic [34:0] p;
		p = 35'(x) * 35'(RECIP_7);
		return p[33:20];
	endfunction

	// Division by 365, exact for any day of the era.
	function automatic logic [YOE_W-1:0] div365(input logic [DOE_W-1:0] x);
		logic [34:0] p;
		p = 35'(x) * 35'(RECIP_365);
		return p[33:25];
	endfunction

	// Division by 153, exact for 5 * doy + 2.
	function automatic logic [MP_W-1:0] div153(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(RECIP_153);
		return p[22:19];
	endfunction

	// Day of the shifted year (March first) on which month mp begins: (153 * mp + 2) / 5.
	function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

### sv/e2c_tod.sv
// Time of day and weekday track: seconds of the day and day count to hour, minute, second, weekday.
module e2c_tod (
	input  logic                       clk,
	input  logic [e2c_pkg::DAYS_W-1:0] days,
	input  logic [e2c_pkg::SOD_W-1:0]  sod,
	output e2c_pkg::tod_t              tod
);

	logic [e2c_pkg::SOD_W-1:0]  sod_s4;
	logic [e2c_pkg::MTOT_W-1:0] mtot_s4;
	logic [e2c_pkg::DAYS_W-1:0] w_s4;
	logic [13:0]                wq_s4;

	logic [e2c_pkg::MTOT_W-1:0] mtot_s5;
	logic [e2c_pkg::HOUR_W-1:0] hour_s5;
	logic [e2c_pkg::MIN_W-1:0]  sec_s5;
	logic [e2c_pkg::WD_W-1:0]   wd_s5;

	e2c_pkg::tod_t tod_s6, tod_s7, tod_s8, tod_s9, tod_s10;

	logic [e2c_pkg::SOD_W-1:0]  sec_full;
	logic [e2c_pkg::DAYS_W-1:0] wd_full;
	logic [e2c_pkg::MTOT_W-1:0] min_full;

	// The weekday of day zero is Thursday, so the count is offset before reduction mod 7.
	always_ff @(posedge clk) begin
		sod_s4  <= sod;
		mtot_s4 <= e2c_pkg::div60_wide(sod);
		w_s4    <= days + e2c_pkg::DAYS_W'(e2c_pkg::WEEKDAY_EPOCH);
		wq_s4   <= e2c_pkg::div7(days + e2c_pkg::DAYS_W'(e2c_pkg::WEEKDAY_EPOCH));
	end

	assign sec_full = sod_s4 - e2c_pkg::SOD_W'(mtot_s4 * 17'd60);
	assign wd_full  = w_s4 - e2c_pkg::DAYS_W'(wq_s4 * 17'd7);

	always_ff @(posedge clk) begin
		mtot_s5 <= mtot_s4;
		hour_s5 <= e2c_pkg::div60_narrow(mtot_s4);
		sec_s5  <= sec_full[e2c_pkg::MIN_W-1:0];
		wd_s5   <= wd_full[e2c_pkg::WD_W-1:0];
	end

	assign min_full = mtot_s5 - e2c_pkg::MTOT_W'(hour_s5 * 11'd60);

	always_ff @(posedge clk) begin
		tod_s6.hour    <= hour_s5;
		tod_s6.minute  <= min_full[e2c_pkg::MIN_W-1:0];
		tod_s6.second  <= sec_s5;
		tod_s6.weekday <= wd_s5;
		// Delay to line up with the calendar track.
		tod_s7  <= tod_s6;
		tod_s8  <= tod_s7;
		tod_s9  <= tod_s8;
		tod_s10 <= tod_s9;
	end

	assign tod = tod_s10;

endmodule

### sv/e2c_civil.sv
// Calendar track: day count since 1970-01-01 to clamped year, month and day.
module e2c_civil (
	input  logic                       clk,
	input  logic [e2c_pkg::DAYS_W-1:0] days,
	output e2c_pkg::civil_t            civil
);

	logic [e2c_pkg::DOE_W-1:0]  doe_s4, doe_s5, doe_s6, doe_s7;
	logic                       era5_s4, era5_s5, era5_s6, era5_s7, era5_s8, era5_s9;
	logic [6:0]                 a_s5;
	logic [2:0]                 b_s5;
	logic                       c_s5;
	logic [e2c_pkg::DOE_W-1:0]  n_s6;
	logic [e2c_pkg::YOE_W-1:0]  yoe_s7, yoe_s8, yoe_s9;
	logic [e2c_pkg::DOY_W-1:0]  doy_s8, doy_s9;
	logic [e2c_pkg::MP_W-1:0]   mp_s9;
	e2c_pkg::civil_t            civil_s10;

	logic                       era5;
	logic [e2c_pkg::DOE_W-1:0]  doe_next;
	logic [e2c_pkg::YOE_W-1:0]  a_full;
	logic [2:0]                 b_next;
	logic [1:0]                 cent;
	logic [e2c_pkg::DOE_W-1:0]  yr_days;
	logic [e2c_pkg::DOE_W-1:0]  doy_full;
	logic [10:0]                mp_num;
	logic [e2c_pkg::DOY_W-1:0]  day_full;
	logic [e2c_pkg::MONTH_W-1:0] month_c;
	logic [e2c_pkg::YFULL_W-1:0] year_full;
	logic [e2c_pkg::YFULL_W-1:0] year_off;
	logic [e2c_pkg::YEAR_W-1:0]  year_c;

	// Stage one: split into era and day of era. Only two eras are reachable.
	assign era5     = days >= e2c_pkg::DAYS_W'(e2c_pkg::ERA_SPLIT);
	assign doe_next = era5 ? e2c_pkg::DOE_W'(days) - e2c_pkg::DOE_W'(e2c_pkg::ERA_SPLIT)
	                       : e2c_pkg::DOE_W'(days) + e2c_pkg::DOE_W'(e2c_pkg::DOE_BIAS);

	always_ff @(posedge clk) begin
		doe_s4  <= doe_next;
		era5_s4 <= era5;
	end

	// Stage two: the leap corrections doe / 1460, doe / 36524 and doe / 146096.
	assign a_full = e2c_pkg::div365(doe_s4 >> 2);

	always_comb begin
		b_next = 3'd0;
		if (doe_s4 >= e2c_pkg::DOE_W'(e2c_pkg::DAYS_PER_CENT_ERA))
			b_next = 3'd1;
		if (doe_s4 >= e2c_pkg::DOE_W'(2 * e2c_pkg::DAYS_PER_CENT_ERA))
			b_next = 3'd2;
		if (doe_s4 >= e2c_pkg::DOE_W'(3 * e2c_pkg::DAYS_PER_CENT_ERA))
			b_next = 3'd3;
		if (doe_s4 >= e2c_pkg::DOE_W'(4 * e2c_pkg::DAYS_PER_CENT_ERA))
			b_next = 3'd4;
	end

	always_ff @(posedge clk) begin
		doe_s5  <= doe_s4;
		era5_s5 <= era5_s4;
		a_s5    <= a_full[6:0];
		b_s5    <= b_next;
		c_s5    <= doe_s4 == e2c_pkg::DOE_W'(e2c_pkg::LAST_DOE);
	end

	// Stage three: corrected day count whose quotient by 365 is the year of the era.
	always_ff @(posedge clk) begin
		doe_s6  <= doe_s5;
		era5_s6 <= era5_s5;
		n_s6    <= doe_s5 - e2c_pkg::DOE_W'(a_s5) + e2c_pkg::DOE_W'(b_s5)
		           - e2c_pkg::DOE_W'(c_s5);
	end

	always_ff @(posedge clk) begin
		doe_s7  <= doe_s6;
		era5_s7 <= era5_s6;
		yoe_s7  <= e2c_pkg::div365(n_s6);
	end

	// Stage five: day of the year counted from March first.
	always_comb begin
		cent = 2'd0;
		if (yoe_s7 >= e2c_pkg::YOE_W'(100))
			cent = 2'd1;
		if (yoe_s7 >= e2c_pkg::YOE_W'(200))
			cent = 2'd2;
		if (yoe_s7 >= e2c_pkg::YOE_W'(300))
			cent = 2'd3;
	end

	assign yr_days  = e2c_pkg::DOE_W'(yoe_s7) * e2c_pkg::DOE_W'(e2c_pkg::DAYS_PER_YEAR)
	                  + e2c_pkg::DOE_W'(yoe_s7 >> 2) - e2c_pkg::DOE_W'(cent);
	assign doy_full = doe_s7 - yr_days;

	always_ff @(posedge clk) begin
		era5_s8 <= era5_s7;
		yoe_s8  <= yoe_s7;
		doy_s8  <= doy_full[e2c_pkg::DOY_W-1:0];
	end

	assign mp_num = 11'(doy_s8) * 11'd5 + 11'd2;

	always_ff @(posedge clk) begin
		era5_s9 <= era5_s8;
		yoe_s9  <= yoe_s8;
		doy_s9  <= doy_s8;
		mp_s9   <= e2c_pkg::div153(mp_num);
	end

	// Last stage: month, day and the clamped year.
	assign day_full = doy_s9 - e2c_pkg::month_start(mp_s9) + 9'd1;
	assign month_c  = (mp_s9 < e2c_pkg::MP_W'(e2c_pkg::MP_MARCH_LAST)) ? mp_s9 + 4'd3
	                                                                   : mp_s9 - 4'd9;
	assign year_full = e2c_pkg::YFULL_W'(yoe_s9)
	                 + (era5_s9 ? e2c_pkg::YFULL_W'(e2c_pkg::YEAR_ERA_HIGH)
	                            : e2c_pkg::YFULL_W'(e2c_pkg::YEAR_ERA_LOW))
	                 + e2c_pkg::YFULL_W'(month_c <= e2c_pkg::MONTH_W'(e2c_pkg::MONTH_FEB));
	assign year_off  = year_full - e2c_pkg::YFULL_W'(e2c_pkg::YEAR_LOW);

	always_comb begin
		priority if (year_full < e2c_pkg::YFULL_W'(e2c_pkg::YEAR_LOW))
			year_c = '0;
		else if (year_full > e2c_pkg::YFULL_W'(e2c_pkg::YEAR_HIGH))
			year_c = e2c_pkg::YEAR_W'(e2c_pkg::YEAR_HIGH - e2c_pkg::YEAR_LOW);
		else
			year_c = year_off[e2c_pkg::YEAR_W-1:0];
	end

	always_ff @(posedge clk) begin
		civil_s10.year_of_century <= year_c;
		civil_s10.month           <= month_c;
		civil_s10.day             <= day_full[e2c_pkg::DAY_W-1:0];
	end

	assign civil = civil_s10;

endmodule

### sv/epoch_seconds_to_calendar.sv
// Top level of the Unix time to local calendar converter.
// A timestamp is taken on any cycle with start high (busy never rises), one per clock.
// Its result appears on the output ports after the ten register stages of the conversion
// pipeline, marked by a one-cycle done strobe, and results leave in the order the
// timestamps came in. The receiver cannot hold a result off, so it must take each
// transfer in the cycle that done is high. The UTC offset in minutes is written on the
// configuration channel, which is always ready; write it only while no conversion is in
// flight. Years are clamped to 2000..2099 while month and day are left as computed, and
// a local time before the epoch is taken as the epoch, which reads as 2000-01-01 00:00:00.
`include "assert_macros.svh"

module epoch_seconds_to_calendar (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [e2c_pkg::SEC_W-1:0]         unix_seconds,
	output logic                              done,
	output logic [e2c_pkg::YEAR_W-1:0]        year_of_century,
	output logic [e2c_pkg::MONTH_W-1:0]       month,
	output logic [e2c_pkg::DAY_W-1:0]         day,
	output logic [e2c_pkg::WD_W-1:0]          weekday,
	output logic [e2c_pkg::HOUR_W-1:0]        hour,
	output logic [e2c_pkg::MIN_W-1:0]         minute,
	output logic [e2c_pkg::MIN_W-1:0]         second,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic signed [e2c_pkg::OFF_W-1:0]  utc_offset_minutes
);

	logic signed [e2c_pkg::OFF_W-1:0]   offset_q;
	logic [e2c_pkg::PIPE_DEPTH-1:0]     stage_vld_q;

	logic [e2c_pkg::T_W-1:0]            t_s1;
	logic [e2c_pkg::DAYS_W-1:0]         q0_s2;
	logic [e2c_pkg::DAY_X_W-1:0]        x_s2;
	logic [e2c_pkg::DAY_SHIFT-1:0]      lo_s2;
	logic [e2c_pkg::DAYS_W-1:0]         days_s3;
	logic [e2c_pkg::SOD_W-1:0]          sod_s3;

	logic signed [e2c_pkg::T_W:0]       off_ext;
	logic signed [e2c_pkg::T_W:0]       local_time;
	logic [e2c_pkg::DAY_PROD_W-1:0]     day_prod;
	logic [e2c_pkg::DAY_REM_W-1:0]      rem;
	logic                               rem_over;
	logic [e2c_pkg::DAY_REM_W-1:0]      rem_fix;
	logic                               accept;
	logic                               fields_ok;
	logic                               month_len_ok;

	e2c_pkg::civil_t                    civil;
	e2c_pkg::tod_t                      tod;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= utc_offset_minutes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			stage_vld_q <= {stage_vld_q[e2c_pkg::PIPE_DEPTH-2:0], accept};
		end
	end

	// Stage one: local time = seconds + 60 * offset, clamped at zero.
	assign off_ext    = (e2c_pkg::T_W + 1)'(offset_q);
	assign local_time = $signed({2'b00, unix_seconds}) + (off_ext <<< 6) - (off_ext <<< 2);

	always_ff @(posedge clk) begin
		t_s1 <= local_time[e2c_pkg::T_W] ? '0 : local_time[e2c_pkg::T_W-1:0];
	end

	// Stage two: estimate the day count from the odd part of 86400, possibly one low.
	assign day_prod = e2c_pkg::DAY_PROD_W'(t_s1[e2c_pkg::T_W-1:e2c_pkg::DAY_SHIFT])
	                * e2c_pkg::DAY_PROD_W'(e2c_pkg::DAY_RECIP);

	always_ff @(posedge clk) begin
		q0_s2 <= day_prod[e2c_pkg::DAY_RECIP_SH +: e2c_pkg::DAYS_W];
		x_s2  <= t_s1[e2c_pkg::T_W-1:e2c_pkg::DAY_SHIFT];
		lo_s2 <= t_s1[e2c_pkg::DAY_SHIFT-1:0];
	end

	// Stage three: one correction step fixes the estimate and yields the seconds of the day.
	assign rem      = e2c_pkg::DAY_REM_W'(x_s2)
	                - e2c_pkg::DAY_REM_W'(q0_s2 * e2c_pkg::DAY_REM_W'(e2c_pkg::DAY_ODD));
	assign rem_over = rem >= e2c_pkg::DAY_REM_W'(e2c_pkg::DAY_ODD);
	assign rem_fix  = rem_over ? rem - e2c_pkg::DAY_REM_W'(e2c_pkg::DAY_ODD) : rem;

	always_ff @(posedge clk) begin
		days_s3 <= q0_s2 + e2c_pkg::DAYS_W'(rem_over);
		sod_s3  <= {rem_fix[e2c_pkg::SOD_W-e2c_pkg::DAY_SHIFT-1:0], lo_s2};
	end

	e2c_civil u_civil (
		.clk   (clk),
		.days  (days_s3),
		.civil (civil)
	);

	e2c_tod u_tod (
		.clk  (clk),
		.days (days_s3),
		.sod  (sod_s3),
		.tod  (tod)
	);

	assign done            = stage_vld_q[e2c_pkg::PIPE_DEPTH-1];
	assign year_of_century = civil.year_of_century;
	assign month           = civil.month;
	assign day             = civil.day;
	assign weekday         = tod.weekday;
	assign hour            = tod.hour;
	assign minute          = tod.minute;
	assign second          = tod.second;

	assign fields_ok    = (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1)
	                    && (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59)
	                    && (weekday <= 3'd6) && (year_of_century <= 7'd99);
	assign month_len_ok = !((day == 5'd31) && ((month == 4'd4) || (month == 4'd6)
	                                           || (month == 4'd9) || (month == 4'd11)))
	                    && !((month == 4'd2) && (day > 5'd29));

	// Every accepted timestamp yields its transfer when it leaves the last pipeline stage.
	`ASSERT_IMP(a_latency, clk, arst_n, accept, ##(e2c_pkg::PIPE_DEPTH) done)

	// Fields of a delivered result lie in their calendar ranges.
	`ASSERT_IMP(a_ranges, clk, arst_n, done, fields_ok)

	// Short months never show a day past 30, and February none past 29.
	`ASSERT_IMP(a_month_len, clk, arst_n, done, month_len_ok)

endmodule
